// ----- rtl/swamm_pkg.sv -----
// ----------------------------------------------------------------------------
// swamm_pkg
// Shared widths, opcodes and the window store command for the sliding
// window mean, maximum and minimum block.
// ----------------------------------------------------------------------------
package swamm_pkg;

    localparam int DATA_W           = 16;
    localparam int SLOT_W           = 8;
    localparam int WINDOW_DEPTH_DEF = 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SET    = 1'b1;

    typedef struct packed {
        logic                     insert;
        logic                     set;
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] sample;
    } t_store_cmd;

endpackage

// ----- rtl/swamm_store.sv -----
// ----------------------------------------------------------------------------
// swamm_store
// Circular window memory with a head pointer. Slot k lives at physical entry
// (head + k) mod depth, so an insert only moves the head and writes one entry.
// ----------------------------------------------------------------------------
module swamm_store #(
    parameter int WINDOW_DEPTH = swamm_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  swamm_pkg::t_store_cmd               i_cmd,
    input  logic [((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1)-1:0] i_rd_addr,
    output logic signed [swamm_pkg::DATA_W-1:0] o_rd_data,
    output logic                                o_clear_busy
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int XW = swamm_pkg::SLOT_W + 1;
    localparam logic [XW-1:0] DEPTH_X = XW'(WINDOW_DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(WINDOW_DEPTH - 1);

    logic signed [swamm_pkg::DATA_W-1:0] r_mem [WINDOW_DEPTH];

    logic [AW-1:0] r_head;
    logic [AW-1:0] n_head;
    logic [AW-1:0] r_clr_cnt;
    logic          r_clearing;
    logic [AW-1:0] head_dec;
    logic [XW-1:0] set_sum;
    logic [XW-1:0] set_wrap;
    logic [AW-1:0] set_addr;

    assign head_dec = (r_head == '0) ? LAST_A : (r_head - AW'(1));
    assign set_sum  = XW'(r_head) + XW'(i_cmd.slot);
    assign set_wrap = (set_sum >= DEPTH_X) ? (set_sum - DEPTH_X) : set_sum;
    assign set_addr = set_wrap[AW-1:0];

    always_comb begin
        n_head = r_head;
        if (!r_clearing && i_cmd.insert) begin
            n_head = head_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_clr_cnt  <= '0;
            r_clearing <= 1'b1;
        end else begin
            r_head <= n_head;
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
                if (r_clr_cnt == LAST_A) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_cnt] <= '0;
        end else if (i_cmd.insert) begin
            r_mem[head_dec] <= i_cmd.sample;
        end else if (i_cmd.set) begin
            r_mem[set_addr] <= i_cmd.sample;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

    assign o_clear_busy = r_clearing;

endmodule

// ----- rtl/swamm_div.sv -----
// ----------------------------------------------------------------------------
// swamm_div
// Division of an unsigned magnitude by a constant through multiplication by
// its rounded-up reciprocal, with the quotient registered in the cycle after start.
// ----------------------------------------------------------------------------
module swamm_div #(
    parameter int DIVISOR = swamm_pkg::WINDOW_DEPTH_DEF,
    parameter int MAG_W   = swamm_pkg::DATA_W + $clog2(swamm_pkg::WINDOW_DEPTH_DEF)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_mag,
    output logic [MAG_W-1:0] o_quot,
    output logic             o_done
);

    localparam int L  = $clog2(DIVISOR);
    localparam int SH = MAG_W + L;
    localparam int MW = MAG_W + 2;
    localparam int PW = MAG_W + SH;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

    logic [PW-1:0]    prod;
    logic [MAG_W-1:0] r_quot;
    logic             r_done;

    assign prod = PW'(i_mag) * PW'(RECIP_M);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= prod[SH +: MAG_W];
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

// ----- rtl/sliding_window_avg_min_max.sv -----
// ----------------------------------------------------------------------------
// sliding_window_avg_min_max
// Window of the last WINDOW_DEPTH signed Q8.8 samples with mean, maximum and
// minimum reported after every item.
// ----------------------------------------------------------------------------
// After reset the block zeroes its window memory and accepts no item during
// that time. For each item, one scan pass then reads every window entry
// through the single memory read port, the mean comes from a reciprocal
// multiplication whose quotient is registered in the divider, and the result
// is loaded into the output register before the block accepts the next item.
// A finished result waits in the output register while the next item is
// accepted; if it is still waiting when the next result is ready, the block
// holds until it is taken.
// ----------------------------------------------------------------------------
module sliding_window_avg_min_max #(
    parameter int WINDOW_DEPTH = swamm_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_opcode,
    input  logic [swamm_pkg::SLOT_W-1:0]        i_slot_index,
    input  logic signed [swamm_pkg::DATA_W-1:0] i_sample_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [swamm_pkg::DATA_W-1:0] o_window_mean,
    output logic signed [swamm_pkg::DATA_W-1:0] o_window_max,
    output logic signed [swamm_pkg::DATA_W-1:0] o_window_min,
    output logic                                o_index_rejected
);

    localparam int DW = swamm_pkg::DATA_W;
    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = DW + $clog2(WINDOW_DEPTH);
    localparam int XW = swamm_pkg::SLOT_W + 1;
    localparam logic [XW-1:0] DEPTH_X = XW'(WINDOW_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [CW-1:0]        r_cnt;
    logic                 r_rej;
    logic signed [SW-1:0] r_sum;
    logic signed [DW-1:0] r_max;
    logic signed [DW-1:0] r_min;
    logic                 r_out_valid;
    logic signed [DW-1:0] r_mean;
    logic signed [DW-1:0] r_omax;
    logic signed [DW-1:0] r_omin;
    logic                 r_orej;

    logic                  in_acc;
    logic                  slot_ok;
    logic                  clr_busy;
    swamm_pkg::t_store_cmd cmd;
    logic [AW-1:0]         rd_addr;
    logic signed [DW-1:0]  rd_data;
    logic                  sum_neg;
    logic [SW-1:0]         sum_mag;
    logic [SW-1:0]         quot;
    logic [SW-1:0]         quot_signed;
    logic                  div_done;
    logic                  out_load;

    assign o_in_ready = (r_state == S_IDLE) && !clr_busy;
    assign in_acc     = i_in_valid && o_in_ready;
    assign slot_ok    = ({1'b0, i_slot_index} < DEPTH_X);

    always_comb begin
        cmd        = '0;
        cmd.slot   = i_slot_index;
        cmd.sample = i_sample_value;
        cmd.insert = in_acc && (i_opcode == swamm_pkg::OP_INSERT);
        cmd.set    = in_acc && (i_opcode == swamm_pkg::OP_SET) && slot_ok;
    end

    assign rd_addr = r_cnt[AW-1:0];

    swamm_store #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_rd_addr   (rd_addr),
        .o_rd_data   (rd_data),
        .o_clear_busy(clr_busy)
    );

    assign sum_neg = r_sum[SW-1];
    assign sum_mag = sum_neg ? (SW'(0) - SW'(r_sum)) : SW'(r_sum);

    swamm_div #(
        .DIVISOR(WINDOW_DEPTH),
        .MAG_W  (SW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_state == S_START),
        .i_mag  (sum_mag),
        .o_quot (quot),
        .o_done (div_done)
    );

    assign quot_signed = sum_neg ? (SW'(0) - quot) : quot;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt == DEPTH_C) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_cnt <= '0;
            end else if (r_state == S_SCAN) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rej <= (i_opcode == swamm_pkg::OP_SET) && !slot_ok;
        end
        if ((r_state == S_SCAN) && (r_cnt != '0)) begin
            if (r_cnt == CW'(1)) begin
                r_sum <= SW'(rd_data);
                r_max <= rd_data;
                r_min <= rd_data;
            end else begin
                r_sum <= r_sum + SW'(rd_data);
                if (rd_data > r_max) begin
                    r_max <= rd_data;
                end
                if (rd_data < r_min) begin
                    r_min <= rd_data;
                end
            end
        end
        if (out_load) begin
            r_mean <= quot_signed[DW-1:0];
            r_omax <= r_max;
            r_omin <= r_min;
            r_orej <= r_rej;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_window_mean    = r_mean;
    assign o_window_max     = r_omax;
    assign o_window_min     = r_omin;
    assign o_index_rejected = r_orej;

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SCAN))
        else $error("Accepted item did not start the window scan.");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt <= DEPTH_C))
        else $error("Scan counter ran past the window depth.");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("Divider finished outside the divide state.");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !o_in_ready)
        else $error("Item accepted while the window memory is being cleared.");

endmodule
